### rtl/rbu_pkg.sv
// ----------------------------------------------------------------------------
// rbu_pkg: shared types and constants
// Stage counts, field widths and calendar constants of the BCD-to-Unix-time
// converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rbu_pkg;

  localparam int FrontStages = 2;
  localparam int QuoW        = 14;          // quotient < 10000
  localparam int DivStages   = QuoW;        // one quotient bit per stage
  localparam int BackStages  = 4;
  localparam int NStages     = FrontStages + DivStages + BackStages;

  localparam int DividendW = 29;            // 32767 * 10000 < 2^29
  localparam int DivisorW  = 16;            // prescaler + 1

  localparam logic [14:0] PrescalerReset = 15'd511;
  localparam logic [31:0] EpochJdn       = 32'd2440588;
  localparam logic [31:0] JdnBias        = 32'd32045;
  localparam logic [12:0] YearBase       = 13'd6800;  // 2000 + 4800
  localparam logic [28:0] FracSteps      = 29'd10000;
  localparam logic [29:0] NsPerStep      = 30'd100000;

  // calendar terms carried alongside the divider
  typedef struct packed {
    logic [9:0]  day_acc;   // day + month offset days
    logic [12:0] yr;        // year + 4800 - early
    logic [6:0]  yc;        // yr / 100
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;
    logic        flag;      // sub-second above prescaler
  } cal_t;

endpackage

`default_nettype wire

### rtl/rbu_front.sv
// ----------------------------------------------------------------------------
// rbu_front: BCD decode and operand setup
// Two stages: digit decode, then dividend product and day-count terms.
// ----------------------------------------------------------------------------
`default_nettype none

module rbu_front (
  input  wire logic                           clk_i,
  input  wire logic [rbu_pkg::FrontStages-1:0] load_i,
  input  wire logic [14:0]                    prescaler_i,
  input  wire logic [15:0]                    sub_second_i,
  input  wire logic [23:0]                    time_bcd_i,
  input  wire logic [23:0]                    date_bcd_i,
  output rbu_pkg::cal_t                       cal_o,
  output logic [rbu_pkg::DividendW-1:0]       dividend_o,
  output logic [rbu_pkg::DivisorW-1:0]        divisor_o
);

  logic [5:0]  day_w;
  logic [4:0]  month_w;
  logic [7:0]  year_w;
  logic        early_w;

  logic [12:0] yr0_q;
  logic [5:0]  day0_q;
  logic [4:0]  moff0_q;
  logic [7:0]  hour0_q, min0_q, sec0_q;
  logic        flag0_q;
  logic [14:0] diff0_q;
  logic [rbu_pkg::DivisorW-1:0] div0_q;

  logic [12:0] mx_w;
  logic [25:0] mprod_w;
  logic [25:0] yprod_w;

  rbu_pkg::cal_t                 cal1_q;
  logic [rbu_pkg::DividendW-1:0] dvd1_q;
  logic [rbu_pkg::DivisorW-1:0]  div1_q;

  always_comb begin
    day_w   = 6'(date_bcd_i[3:0]) + 6'(date_bcd_i[5:4]) * 6'd10;
    month_w = 5'(date_bcd_i[11:8]) + 5'(date_bcd_i[12]) * 5'd10;
    year_w  = 8'(date_bcd_i[19:16]) + 8'(date_bcd_i[23:20]) * 8'd10;
    early_w = (month_w <= 5'd2);
  end

  always_ff @(posedge clk_i) begin
    if (load_i[0]) begin
      yr0_q   <= 13'(year_w) + rbu_pkg::YearBase - 13'(early_w);
      day0_q  <= day_w;
      moff0_q <= early_w ? (month_w + 5'd9) : (month_w - 5'd3);
      sec0_q  <= 8'(time_bcd_i[3:0]) + 8'(time_bcd_i[7:4]) * 8'd10;
      min0_q  <= 8'(time_bcd_i[11:8]) + 8'(time_bcd_i[15:12]) * 8'd10;
      hour0_q <= 8'(time_bcd_i[19:16]) + 8'(time_bcd_i[23:20]) * 8'd10;
      flag0_q <= (sub_second_i > {1'b0, prescaler_i});
      diff0_q <= prescaler_i - sub_second_i[14:0];
      div0_q  <= {1'b0, prescaler_i} + 16'd1;
    end
  end

  // (153*m + 2) / 5 and yr / 100 by reciprocal multiply; exact over the ranges
  always_comb begin
    mx_w    = 13'(moff0_q) * 13'd153 + 13'd2;
    mprod_w = 26'(mx_w) * 26'd6554;
    yprod_w = 26'(yr0_q) * 26'd5243;
  end

  always_ff @(posedge clk_i) begin
    if (load_i[1]) begin
      cal1_q.day_acc <= 10'(day0_q) + mprod_w[24:15];
      cal1_q.yr      <= yr0_q;
      cal1_q.yc      <= yprod_w[25:19];
      cal1_q.hour    <= hour0_q;
      cal1_q.minute  <= min0_q;
      cal1_q.second  <= sec0_q;
      cal1_q.flag    <= flag0_q;
      dvd1_q         <= 29'(diff0_q) * rbu_pkg::FracSteps;
      div1_q         <= div0_q;
    end
  end

  assign cal_o      = cal1_q;
  assign dividend_o = dvd1_q;
  assign divisor_o  = div1_q;

endmodule

`default_nettype wire

### rtl/rbu_frac_div.sv
// ----------------------------------------------------------------------------
// rbu_frac_div: pipelined restoring divider
// One quotient bit per stage, MSB first; calendar terms ride along.
// ----------------------------------------------------------------------------
`default_nettype none

module rbu_frac_div (
  input  wire logic                             clk_i,
  input  wire logic [rbu_pkg::DivStages-1:0]    load_i,
  input  wire logic [rbu_pkg::DividendW-1:0]    dividend_i,
  input  wire logic [rbu_pkg::DivisorW-1:0]     divisor_i,
  input  wire rbu_pkg::cal_t                    cal_i,
  output logic [rbu_pkg::QuoW-1:0]              quotient_o,
  output rbu_pkg::cal_t                         cal_o
);

  localparam int RemW = rbu_pkg::DividendW;
  localparam int N    = rbu_pkg::DivStages;

  logic [RemW-1:0]             rem_q [N];
  logic [rbu_pkg::QuoW-1:0]    quo_q [N];
  logic [rbu_pkg::DivisorW-1:0] div_q [N];
  rbu_pkg::cal_t               cal_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [RemW-1:0]              rem_in;
    logic [rbu_pkg::QuoW-1:0]     quo_in;
    logic [rbu_pkg::DivisorW-1:0] div_in;
    rbu_pkg::cal_t                cal_in;
    logic [RemW:0]                sh;
    logic                         ge;

    if (k == 0) begin : g_first
      assign rem_in = dividend_i;
      assign quo_in = '0;
      assign div_in = divisor_i;
      assign cal_in = cal_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
      assign div_in = div_q[k-1];
      assign cal_in = cal_q[k-1];
    end

    always_comb begin
      sh = (RemW + 1)'(div_in) << (N - 1 - k);
      ge = ({1'b0, rem_in} >= sh);
    end

    always_ff @(posedge clk_i) begin
      if (load_i[k]) begin
        rem_q[k] <= ge ? RemW'({1'b0, rem_in} - sh) : rem_in;
        quo_q[k] <= quo_in | (rbu_pkg::QuoW'(ge) << (N - 1 - k));
        div_q[k] <= div_in;
        cal_q[k] <= cal_in;
      end
    end
  end

  assign quotient_o = quo_q[N-1];
  assign cal_o      = cal_q[N-1];

endmodule

`default_nettype wire

### rtl/rbu_back.sv
// ----------------------------------------------------------------------------
// rbu_back: day count and seconds assembly
// Julian day sum, then hours, minutes and seconds folded in one per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rbu_back (
  input  wire logic                            clk_i,
  input  wire logic [rbu_pkg::BackStages-1:0]  load_i,
  input  wire logic [rbu_pkg::QuoW-1:0]        quotient_i,
  input  wire rbu_pkg::cal_t                   cal_i,
  output logic [31:0]                          unix_seconds_o,
  output logic [29:0]                          nanoseconds_o,
  output logic                                 shift_flag_o
);

  logic [31:0] days_q, t1_q, t2_q, t3_q;
  logic [29:0] ns0_q, ns1_q, ns2_q, ns3_q;
  logic [7:0]  h0_q, m0_q, s0_q, m1_q, s1_q, s2_q;
  logic        f0_q, f1_q, f2_q, f3_q;

  always_ff @(posedge clk_i) begin
    if (load_i[0]) begin
      days_q <= 32'(cal_i.day_acc) + 32'(cal_i.yr) * 32'd365 + 32'(cal_i.yr >> 2)
                - 32'(cal_i.yc) + 32'(cal_i.yc >> 2)
                - rbu_pkg::JdnBias - rbu_pkg::EpochJdn;
      ns0_q  <= cal_i.flag ? '0 : 30'(quotient_i) * rbu_pkg::NsPerStep;
      h0_q   <= cal_i.hour;
      m0_q   <= cal_i.minute;
      s0_q   <= cal_i.second;
      f0_q   <= cal_i.flag;
    end
    if (load_i[1]) begin
      t1_q  <= days_q * 32'd24 + 32'(h0_q);
      ns1_q <= ns0_q;
      m1_q  <= m0_q;
      s1_q  <= s0_q;
      f1_q  <= f0_q;
    end
    if (load_i[2]) begin
      t2_q  <= t1_q * 32'd60 + 32'(m1_q);
      ns2_q <= ns1_q;
      s2_q  <= s1_q;
      f2_q  <= f1_q;
    end
    if (load_i[3]) begin
      t3_q  <= t2_q * 32'd60 + 32'(s2_q) - 32'(f2_q);
      ns3_q <= ns2_q;
      f3_q  <= f2_q;
    end
  end

  assign unix_seconds_o = t3_q;
  assign nanoseconds_o  = ns3_q;
  assign shift_flag_o   = f3_q;

endmodule

`default_nettype wire

### rtl/rtc_bcd_to_unix_time.sv
// ----------------------------------------------------------------------------
// rtc_bcd_to_unix_time: calendar clock snapshot to Unix time
// Converts BCD time/date (years 2000-2099) plus sub-second count into Unix
// seconds, nanoseconds and a shift flag.
// ----------------------------------------------------------------------------
// One transaction in, one transaction out; unless a full pipeline stalls, a new
// transaction may enter every cycle. The pipeline is two decode/setup stages,
// fourteen restoring-divider stages (one quotient bit each, producing
// (prescaler - sub_second) * 10000 / (prescaler + 1)), and four stages that sum
// the Julian day number and fold in hours, minutes and seconds. Each stage holds
// its own valid bit and loads whenever it is empty or the stage after it moves,
// so bubbles close up under back-pressure and nothing is dropped or repeated;
// the last stage is the output register. sync_prescaler sits at APB address 0
// (reset 511) and should only be written while no transaction is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module rtc_bcd_to_unix_time (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input transaction
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] sub_second_i,
  input  wire logic [23:0] time_bcd_i,
  input  wire logic [23:0] date_bcd_i,
  // output transaction
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      unix_seconds_o,
  output logic [29:0]      nanoseconds_o,
  output logic             shift_flag_o,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int N  = rbu_pkg::NStages;
  localparam int F  = rbu_pkg::FrontStages;
  localparam int D  = rbu_pkg::DivStages;

  logic [14:0]  prescaler_q;
  logic [N-1:0] valid_q;
  logic [N:0]   load_w;

  rbu_pkg::cal_t                  cal_front, cal_div;
  logic [rbu_pkg::DividendW-1:0]  dividend;
  logic [rbu_pkg::DivisorW-1:0]   divisor;
  logic [rbu_pkg::QuoW-1:0]       quotient;

  // APB register: word 0 is the prescaler
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {17'd0, prescaler_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescaler_q <= rbu_pkg::PrescalerReset;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      prescaler_q <= pwdata[14:0];
    end
  end

  // stage k loads when empty or when stage k+1 loads
  always_comb begin
    load_w[N] = out_ready_i;
    for (int k = N - 1; k >= 0; k--) begin
      load_w[k] = !valid_q[k] || load_w[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (load_w[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < N; k++) begin
        if (load_w[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  assign in_ready_o  = load_w[0];
  assign out_valid_o = valid_q[N-1];

  rbu_front u_front (
    .clk_i        (clk_i),
    .load_i       (load_w[F-1:0]),
    .prescaler_i  (prescaler_q),
    .sub_second_i (sub_second_i),
    .time_bcd_i   (time_bcd_i),
    .date_bcd_i   (date_bcd_i),
    .cal_o        (cal_front),
    .dividend_o   (dividend),
    .divisor_o    (divisor)
  );

  rbu_frac_div u_div (
    .clk_i      (clk_i),
    .load_i     (load_w[F+D-1:F]),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .cal_i      (cal_front),
    .quotient_o (quotient),
    .cal_o      (cal_div)
  );

  rbu_back u_back (
    .clk_i          (clk_i),
    .load_i         (load_w[N-1:F+D]),
    .quotient_i     (quotient),
    .cal_i          (cal_div),
    .unix_seconds_o (unix_seconds_o),
    .nanoseconds_o  (nanoseconds_o),
    .shift_flag_o   (shift_flag_o)
  );

endmodule

`default_nettype wire
